>>> hw/rtl/bracketed_turtle_interpreter_assert.svh
// Assertion macros for the bracketed turtle interpreter.
`ifndef BRACKETED_TURTLE_INTERPRETER_ASSERT_SVH
`define BRACKETED_TURTLE_INTERPRETER_ASSERT_SVH

// Same-cycle implication, checked on clk and disabled during reset.
`define BTI_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk and disabled during reset.
`define BTI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/bti_pkg.sv
// Package with constants, codes and the arctangent table of the turtle interpreter.
package bti_pkg;

	localparam int STACK_DEPTH  = 64;
	localparam int CORDIC_STEPS = 16;

	localparam int LEVEL_W = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int ITER_W  = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

	localparam int HEAD_W  = 16;
	localparam int POS_W   = 32;
	localparam int ENTRY_W = HEAD_W + 2 * POS_W;
	localparam int TRIG_W  = 34;
	localparam int ANG_W   = 33;
	localparam int STEP_W  = 24;
	localparam int PROD_W  = STEP_W + 1 + TRIG_W;
	localparam int CFG_W   = 24;

	localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = TRIG_W'(652032874);

	localparam logic [3:0] SYM_G     = 4'd0;
	localparam logic [3:0] SYM_F     = 4'd1;
	localparam logic [3:0] SYM_PUSH  = 4'd2;
	localparam logic [3:0] SYM_POP   = 4'd3;
	localparam logic [3:0] SYM_PLUS  = 4'd4;
	localparam logic [3:0] SYM_MINUS = 4'd5;

	localparam logic [1:0] ST_SEGMENT   = 2'd0;
	localparam logic [1:0] ST_POP_EMPTY = 2'd1;
	localparam logic [1:0] ST_PUSH_FULL = 2'd2;

	localparam logic REG_TURN_ANGLE  = 1'b0;
	localparam logic REG_STEP_LENGTH = 1'b1;

	function automatic logic signed [ANG_W-1:0] atan_entry(input logic [4:0] idx);
		logic signed [ANG_W-1:0] v;
		case (idx)
			5'd0:    v = ANG_W'(536870912);
			5'd1:    v = ANG_W'(316933406);
			5'd2:    v = ANG_W'(167458907);
			5'd3:    v = ANG_W'(85004756);
			5'd4:    v = ANG_W'(42667331);
			5'd5:    v = ANG_W'(21354465);
			5'd6:    v = ANG_W'(10679838);
			5'd7:    v = ANG_W'(5340245);
			5'd8:    v = ANG_W'(2670163);
			5'd9:    v = ANG_W'(1335087);
			5'd10:   v = ANG_W'(667544);
			5'd11:   v = ANG_W'(333772);
			5'd12:   v = ANG_W'(166886);
			5'd13:   v = ANG_W'(83443);
			5'd14:   v = ANG_W'(41722);
			5'd15:   v = ANG_W'(20861);
			5'd16:   v = ANG_W'(10430);
			5'd17:   v = ANG_W'(5215);
			5'd18:   v = ANG_W'(2608);
			5'd19:   v = ANG_W'(1304);
			5'd20:   v = ANG_W'(652);
			5'd21:   v = ANG_W'(326);
			5'd22:   v = ANG_W'(163);
			5'd23:   v = ANG_W'(81);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

>>> hw/rtl/bracketed_turtle_interpreter.sv
// Turtle interpreter for bracketed 2-D strings with a shared CORDIC unit and state stack.
// A draw passes decode, the CORDIC loop, two multiplies, rounding and the position update.
// Turns and no-ops end at decode, pops restore from the stack; CORDIC does one rotation per cycle.
// A new item is taken only when the sequencer is idle; a finished result waits in its own register.
// Asynchronous reset clears the turtle, the stack level and the config registers (step 1.0).
// The stack memory is not cleared; entries are read only after they have been pushed.
`include "bracketed_turtle_interpreter_assert.svh"

module bracketed_turtle_interpreter import bti_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic                    cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	input  logic                    item_valid,
	output logic                    item_stall,
	input  logic [3:0]              symbol,
	input  logic                    first_of_string,
	output logic                    result_valid,
	input  logic                    result_stall,
	output logic signed [POS_W-1:0] start_x,
	output logic signed [POS_W-1:0] start_y,
	output logic signed [POS_W-1:0] end_x,
	output logic signed [POS_W-1:0] end_y,
	output logic [1:0]              status
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DECODE = 4'd1;
	localparam logic [3:0] S_CORDIC = 4'd2;
	localparam logic [3:0] S_MULS   = 4'd3;
	localparam logic [3:0] S_MULC   = 4'd4;
	localparam logic [3:0] S_RNDC   = 4'd5;
	localparam logic [3:0] S_UPD    = 4'd6;
	localparam logic [3:0] S_POP    = 4'd7;
	localparam logic [3:0] S_ERR    = 4'd8;

	localparam logic [ITER_W-1:0]  ITER_LAST = ITER_W'(CORDIC_STEPS - 1);
	localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(STACK_DEPTH);
	localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(64'sd536870912);
	localparam logic signed [POS_W+2:0] POS_MAX = (POS_W+3)'(64'sd2147483647);
	localparam logic signed [POS_W+2:0] POS_MIN = (POS_W+3)'(-64'sd2147483648);

	logic [3:0]               state_q;
	logic [3:0]               sym_q;
	logic [HEAD_W-1:0]        turn_angle_q;
	logic [STEP_W-1:0]        step_length_q;
	logic [HEAD_W-1:0]        heading_q;
	logic signed [POS_W-1:0]  pos_x_q;
	logic signed [POS_W-1:0]  pos_y_q;
	logic [LEVEL_W-1:0]       level_q;
	logic [ITER_W-1:0]        iter_q;
	logic signed [TRIG_W-1:0] cx_q;
	logic signed [TRIG_W-1:0] cy_q;
	logic signed [ANG_W-1:0]  cz_q;
	logic                     neg_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [TRIG_W-1:0] dx_q;
	logic signed [TRIG_W-1:0] dy_q;
	logic [1:0]               err_q;
	logic [ENTRY_W-1:0]       rd_data_q;
	logic [ENTRY_W-1:0]       stack_mem [STACK_DEPTH];
	logic                     result_valid_q;
	logic signed [POS_W-1:0]  start_x_q;
	logic signed [POS_W-1:0]  start_y_q;
	logic signed [POS_W-1:0]  end_x_q;
	logic signed [POS_W-1:0]  end_y_q;
	logic [1:0]               status_q;

	logic                     item_xfer;
	logic                     out_free;
	logic                     res_load;
	logic                     fold;
	logic [HEAD_W-1:0]        head_fold;
	logic signed [TRIG_W-1:0] x_sh;
	logic signed [TRIG_W-1:0] y_sh;
	logic signed [ANG_W-1:0]  atan_v;
	logic signed [TRIG_W-1:0] cx_d;
	logic signed [TRIG_W-1:0] cy_d;
	logic signed [ANG_W-1:0]  cz_d;
	logic signed [TRIG_W-1:0] sin_v;
	logic signed [TRIG_W-1:0] cos_v;
	logic signed [STEP_W:0]   mul_a;
	logic signed [TRIG_W-1:0] mul_b;
	logic signed [PROD_W-1:0] prod_d;
	logic signed [PROD_W-1:0] rnd_sum;
	logic signed [PROD_W-1:0] rnd_shift;
	logic signed [TRIG_W-1:0] delta_d;
	logic signed [POS_W+2:0]  sum_x;
	logic signed [POS_W+2:0]  sum_y;
	logic signed [POS_W-1:0]  new_x;
	logic signed [POS_W-1:0]  new_y;
	logic [ADDR_W-1:0]        wr_addr;
	logic [ADDR_W-1:0]        rd_addr;

	assign item_xfer  = item_valid && !item_stall;
	assign item_stall = (state_q != S_IDLE);
	assign out_free   = !result_valid_q || !result_stall;
	assign res_load   = out_free && (state_q == S_UPD || state_q == S_ERR);

	assign fold      = heading_q[15] ^ heading_q[14];
	assign head_fold = heading_q ^ {fold, {(HEAD_W-1){1'b0}}};

	assign x_sh   = cx_q >>> iter_q;
	assign y_sh   = cy_q >>> iter_q;
	assign atan_v = atan_entry(5'(iter_q));

	always_comb begin
		if (!cz_q[ANG_W-1]) begin
			cx_d = cx_q - y_sh;
			cy_d = cy_q + x_sh;
			cz_d = cz_q - atan_v;
		end else begin
			cx_d = cx_q + y_sh;
			cy_d = cy_q - x_sh;
			cz_d = cz_q + atan_v;
		end
	end

	assign sin_v  = neg_q ? -cy_q : cy_q;
	assign cos_v  = neg_q ? -cx_q : cx_q;
	assign mul_a  = $signed({1'b0, step_length_q});
	assign mul_b  = (state_q == S_MULS) ? sin_v : cos_v;
	assign prod_d = mul_a * mul_b;

	assign rnd_sum   = prod_q + ROUND_HALF;
	assign rnd_shift = rnd_sum >>> 30;
	assign delta_d   = rnd_shift[TRIG_W-1:0];

	assign sum_x = (POS_W+3)'(pos_x_q) + (POS_W+3)'(dx_q);
	assign sum_y = (POS_W+3)'(pos_y_q) + (POS_W+3)'(dy_q);

	always_comb begin
		if (sum_x > POS_MAX) begin
			new_x = POS_MAX[POS_W-1:0];
		end else if (sum_x < POS_MIN) begin
			new_x = POS_MIN[POS_W-1:0];
		end else begin
			new_x = sum_x[POS_W-1:0];
		end
		if (sum_y > POS_MAX) begin
			new_y = POS_MAX[POS_W-1:0];
		end else if (sum_y < POS_MIN) begin
			new_y = POS_MIN[POS_W-1:0];
		end else begin
			new_y = sum_y[POS_W-1:0];
		end
	end

	assign wr_addr = level_q[ADDR_W-1:0];
	assign rd_addr = level_q[ADDR_W-1:0] - ADDR_W'(1);

	always_ff @(posedge clk) begin
		if (state_q == S_DECODE && sym_q == SYM_PUSH && level_q < LEVEL_MAX) begin
			stack_mem[wr_addr] <= {heading_q, pos_x_q, pos_y_q};
		end
		rd_data_q <= stack_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turn_angle_q  <= '0;
			step_length_q <= STEP_W'(65536);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TURN_ANGLE:  turn_angle_q  <= cfg_data[HEAD_W-1:0];
				REG_STEP_LENGTH: step_length_q <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		iter_q <= iter_q;
		case (state_q)
			S_DECODE: begin
				cx_q   <= CORDIC_GAIN;
				cy_q   <= '0;
				cz_q   <= $signed({head_fold[HEAD_W-1], head_fold, 16'b0});
				neg_q  <= fold;
				iter_q <= '0;
			end
			S_CORDIC: begin
				cx_q   <= cx_d;
				cy_q   <= cy_d;
				cz_q   <= cz_d;
				iter_q <= iter_q + ITER_W'(1);
			end
			S_MULS: begin
				prod_q <= prod_d;
			end
			S_MULC: begin
				dx_q   <= delta_d;
				prod_q <= prod_d;
			end
			S_RNDC: begin
				dy_q <= delta_d;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			sym_q          <= '0;
			heading_q      <= '0;
			pos_x_q        <= '0;
			pos_y_q        <= '0;
			level_q        <= '0;
			err_q          <= ST_SEGMENT;
			result_valid_q <= 1'b0;
			start_x_q      <= '0;
			start_y_q      <= '0;
			end_x_q        <= '0;
			end_y_q        <= '0;
			status_q       <= ST_SEGMENT;
		end else begin
			if (res_load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (item_xfer) begin
						sym_q   <= symbol;
						state_q <= S_DECODE;
						if (first_of_string) begin
							heading_q <= '0;
							pos_x_q   <= '0;
							pos_y_q   <= '0;
							level_q   <= '0;
						end
					end
				end
				S_DECODE: begin
					case (sym_q)
						SYM_G, SYM_F: begin
							state_q <= S_CORDIC;
						end
						SYM_PUSH: begin
							if (level_q < LEVEL_MAX) begin
								level_q <= level_q + LEVEL_W'(1);
								state_q <= S_IDLE;
							end else begin
								err_q   <= ST_PUSH_FULL;
								state_q <= S_ERR;
							end
						end
						SYM_POP: begin
							if (level_q != '0) begin
								level_q <= level_q - LEVEL_W'(1);
								state_q <= S_POP;
							end else begin
								err_q   <= ST_POP_EMPTY;
								state_q <= S_ERR;
							end
						end
						SYM_PLUS: begin
							heading_q <= heading_q - turn_angle_q;
							state_q   <= S_IDLE;
						end
						SYM_MINUS: begin
							heading_q <= heading_q + turn_angle_q;
							state_q   <= S_IDLE;
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end
				S_CORDIC: begin
					if (iter_q == ITER_LAST) begin
						state_q <= S_MULS;
					end
				end
				S_MULS: begin
					state_q <= S_MULC;
				end
				S_MULC: begin
					state_q <= S_RNDC;
				end
				S_RNDC: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					if (out_free) begin
						start_x_q <= pos_x_q;
						start_y_q <= pos_y_q;
						end_x_q   <= new_x;
						end_y_q   <= new_y;
						status_q  <= ST_SEGMENT;
						pos_x_q   <= new_x;
						pos_y_q   <= new_y;
						state_q   <= S_IDLE;
					end
				end
				S_POP: begin
					heading_q <= rd_data_q[ENTRY_W-1 -: HEAD_W];
					pos_x_q   <= rd_data_q[2*POS_W-1 -: POS_W];
					pos_y_q   <= rd_data_q[POS_W-1:0];
					state_q   <= S_IDLE;
				end
				S_ERR: begin
					if (out_free) begin
						start_x_q <= '0;
						start_y_q <= '0;
						end_x_q   <= '0;
						end_y_q   <= '0;
						status_q  <= err_q;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign start_x      = start_x_q;
	assign start_y      = start_y_q;
	assign end_x        = end_x_q;
	assign end_y        = end_y_q;
	assign status       = status_q;

	`BTI_ASSERT_NOW(a_level_bound, 1'b1, level_q <= LEVEL_MAX, "stack level above depth")
	`BTI_ASSERT_NEXT(a_busy_after_xfer, item_xfer, state_q == S_DECODE, "no decode after transfer")
	`BTI_ASSERT_NOW(a_err_points_zero, result_valid_q && status_q != ST_SEGMENT, start_x_q == '0 && end_y_q == '0, "error result with nonzero points")
	`BTI_ASSERT_NEXT(a_cordic_to_mul, state_q == S_CORDIC && iter_q == ITER_LAST, state_q == S_MULS, "CORDIC did not end at last step")

endmodule

>>> tb/tb.sv
// Self-checking testbench for the bracketed turtle interpreter: directed table, then random strings.
`timescale 1ns / 1ps

module tb import bti_pkg::*;;

	localparam logic [3:0] SYM_NOP_LO  = 4'd6;
	localparam logic [3:0] SYM_NOP_MID = 4'd7;
	localparam logic [3:0] SYM_NOP_HI  = 4'd8;

	localparam int SETTLE_CYCLES = 30;
	localparam int DRAIN_CYCLES  = 40;
	localparam int HOLD_CYCLES   = 300;
	localparam int QUIET_LIMIT   = 5000;
	localparam int PHASE_ITEMS   = 70;
	localparam int SAT_RUN       = 135;

	localparam longint POS_MAX    = 64'sh0000_0000_7FFF_FFFF;
	localparam longint POS_MIN    = -POS_MAX - 1;
	localparam longint ROUND_HALF = 64'sd536870912;
	localparam longint UNIT_GAIN  = 64'sd652032874;

	localparam longint ATAN_TAB [0:23] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81
	};

	typedef struct packed {
		logic signed [31:0] sx;
		logic signed [31:0] sy;
		logic signed [31:0] ex;
		logic signed [31:0] ey;
		logic [1:0]         st;
	} segment_t;

	typedef enum logic {ROW_SYMBOL, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic [3:0]  sym;
		logic        first;
		int          reps;
		logic        cfg_idx;
		logic [23:0] value;
		bit          typed;
		segment_t    want;
	} plan_row_t;

	localparam segment_t POP_EMPTY_SEG = '{sx: '0, sy: '0, ex: '0, ey: '0, st: ST_POP_EMPTY};
	localparam segment_t PUSH_FULL_SEG = '{sx: '0, sy: '0, ex: '0, ey: '0, st: ST_PUSH_FULL};
	localparam segment_t ORIGIN_SEG    = '{sx: '0, sy: '0, ex: '0, ey: '0, st: ST_SEGMENT};

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic                    cfg_index;
	logic [CFG_W-1:0]        cfg_data;
	logic                    item_valid;
	logic                    item_stall;
	logic [3:0]              symbol;
	logic                    first_of_string;
	logic                    result_valid;
	logic                    result_stall;
	logic signed [POS_W-1:0] start_x;
	logic signed [POS_W-1:0] start_y;
	logic signed [POS_W-1:0] end_x;
	logic signed [POS_W-1:0] end_y;
	logic [1:0]              status;

	bracketed_turtle_interpreter uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.symbol(symbol),
		.first_of_string(first_of_string),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.start_x(start_x),
		.start_y(start_y),
		.end_x(end_x),
		.end_y(end_y),
		.status(status)
	);

	logic [15:0]        cfg_turn = 16'd0;
	logic [23:0]        cfg_step = 24'd65536;
	logic [15:0]        t_heading = '0;
	logic signed [31:0] t_x = '0;
	logic signed [31:0] t_y = '0;
	int                 t_level = 0;
	logic [15:0]        saved_heading [STACK_DEPTH];
	logic signed [31:0] saved_x [STACK_DEPTH];
	logic signed [31:0] saved_y [STACK_DEPTH];

	segment_t  segments [$];
	plan_row_t plan [$];
	segment_t  drive_want;
	bit        drive_typed;
	bit        calm = 0;
	bit        hold_req = 0;
	int        faults = 0;
	int        items_sent = 0;
	int        quiet = 0;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic void cordic_sin_cos(input logic [15:0] h, output longint sn,
			output longint cs);
		logic [31:0] zu;
		bit          flip;
		longint      x;
		longint      y;
		longint      z;
		longint      nx;
		zu = {h, 16'h0000};
		flip = (h >= 16'd16384) && (h < 16'd49152);
		if (flip)
			zu = zu + 32'h8000_0000;
		z = longint'($signed(zu));
		x = UNIT_GAIN;
		y = 0;
		for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z = z - ATAN_TAB[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z = z + ATAN_TAB[i];
			end
			x = nx;
		end
		cs = flip ? -x : x;
		sn = flip ? -y : y;
	endfunction

	function automatic logic signed [31:0] clamp32(input longint v);
		if (v > POS_MAX)
			return 32'sh7FFF_FFFF;
		if (v < POS_MIN)
			return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic bit advance_turtle(input logic [3:0] sym, input logic first,
			output segment_t seg);
		longint sn;
		longint cs;
		longint dx;
		longint dy;
		seg = '0;
		if (first) begin
			t_heading = '0;
			t_x = '0;
			t_y = '0;
			t_level = 0;
		end
		case (sym)
			SYM_G, SYM_F: begin
				cordic_sin_cos(t_heading, sn, cs);
				dx = (longint'(cfg_step) * sn + ROUND_HALF) >>> 30;
				dy = (longint'(cfg_step) * cs + ROUND_HALF) >>> 30;
				seg.sx = t_x;
				seg.sy = t_y;
				seg.ex = clamp32(longint'(t_x) + dx);
				seg.ey = clamp32(longint'(t_y) + dy);
				seg.st = ST_SEGMENT;
				t_x = seg.ex;
				t_y = seg.ey;
				return 1'b1;
			end
			SYM_PUSH: begin
				if (t_level >= STACK_DEPTH) begin
					seg.st = ST_PUSH_FULL;
					return 1'b1;
				end
				saved_heading[t_level] = t_heading;
				saved_x[t_level] = t_x;
				saved_y[t_level] = t_y;
				t_level++;
			end
			SYM_POP: begin
				if (t_level == 0) begin
					seg.st = ST_POP_EMPTY;
					return 1'b1;
				end
				t_level--;
				t_heading = saved_heading[t_level];
				t_x = saved_x[t_level];
				t_y = saved_y[t_level];
			end
			SYM_PLUS:  t_heading = t_heading - cfg_turn;
			SYM_MINUS: t_heading = t_heading + cfg_turn;
			default: ;
		endcase
		return 1'b0;
	endfunction

	always @(posedge clk) begin
		segment_t seg;
		segment_t want;
		if (arst_n) begin
			if (cfg_we) begin
				if (cfg_index == REG_TURN_ANGLE)
					cfg_turn = cfg_data[15:0];
				else
					cfg_step = cfg_data;
			end
			if (item_valid && !item_stall) begin
				if (advance_turtle(symbol, first_of_string, seg))
					segments.insert(segments.size(), drive_typed ? drive_want : seg);
			end
			if (result_valid && !result_stall) begin
				if (segments.size() == 0) begin
					if (faults < 10)
						$display("%0t: result with nothing expected: %h %h %h %h st=%0d",
							$time, start_x, start_y, end_x, end_y, status);
					faults++;
				end else begin
					want = segments.pop_front();
					if (start_x !== want.sx || start_y !== want.sy || end_x !== want.ex ||
							end_y !== want.ey || status !== want.st) begin
						if (faults < 10)
							$display("%0t: got %h %h %h %h st=%0d, expected %h %h %h %h st=%0d",
								$time, start_x, start_y, end_x, end_y, status,
								want.sx, want.sy, want.ex, want.ey, want.st);
						faults++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
			quiet = 0;
		else
			quiet++;
		if (quiet == QUIET_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				result_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 0;
			end
			result_stall = !calm && ($urandom_range(99) < 8);
		end
	end

	task automatic send_symbol(input logic [3:0] sym, input logic first, input bit typed,
			input segment_t want);
		while (!calm && $urandom_range(99) < 8) begin
			item_valid = 1'b0;
			@(negedge clk);
		end
		item_valid = 1'b1;
		symbol = sym;
		first_of_string = first;
		drive_typed = typed;
		drive_want = want;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_plain(input logic [3:0] sym, input logic first);
		send_symbol(sym, first, 1'b0, '0);
	endtask

	task automatic wait_drained();
		item_valid = 1'b0;
		while (segments.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [23:0] value);
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic send_string();
		int         len;
		int         depth;
		int         r;
		logic [3:0] sym;
		depth = 0;
		len = $urandom_range(40, 4);
		send_plain(4'($urandom_range(8)), 1'b1);
		for (int k = 0; k < len; k++) begin
			r = $urandom_range(99);
			if (r < 15 && depth < STACK_DEPTH) begin
				sym = SYM_PUSH;
				depth++;
			end else if (r < 28 && depth > 0) begin
				sym = SYM_POP;
				depth--;
			end else if (r < 60) begin
				sym = $urandom_range(1) ? SYM_G : SYM_F;
			end else if (r < 85) begin
				sym = $urandom_range(1) ? SYM_PLUS : SYM_MINUS;
			end else begin
				sym = 4'($urandom_range(8, 6));
			end
			send_plain(sym, 1'b0);
		end
		while (depth > 0) begin
			send_plain(SYM_POP, 1'b0);
			depth--;
		end
	endtask

	task automatic send_pile();
		int n;
		n = $urandom_range(STACK_DEPTH + 3, STACK_DEPTH - 3);
		send_plain(SYM_PUSH, 1'b1);
		repeat (n - 1) send_plain(($urandom_range(3) == 0) ? SYM_G : SYM_PUSH, 1'b0);
		repeat (n + 1) send_plain(SYM_POP, 1'b0);
	endtask

	task automatic send_noise();
		repeat ($urandom_range(10, 1))
			send_plain(4'($urandom_range(8)), $urandom_range(7) == 0);
	endtask

	function automatic plan_row_t symbol_row(input logic [3:0] sym, input logic first,
			input int reps);
		plan_row_t r;
		r.kind = ROW_SYMBOL;
		r.sym = sym;
		r.first = first;
		r.reps = reps;
		r.cfg_idx = REG_TURN_ANGLE;
		r.value = '0;
		r.typed = 1'b0;
		r.want = '0;
		return r;
	endfunction

	function automatic plan_row_t typed_row(input logic [3:0] sym, input logic first,
			input segment_t want);
		plan_row_t r;
		r = symbol_row(sym, first, 1);
		r.typed = 1'b1;
		r.want = want;
		return r;
	endfunction

	function automatic plan_row_t reg_row(input logic idx, input logic [23:0] value);
		plan_row_t r;
		r = symbol_row(SYM_G, 1'b0, 0);
		r.kind = ROW_REG;
		r.cfg_idx = idx;
		r.value = value;
		return r;
	endfunction

	function automatic void add_row(input plan_row_t r);
		plan.insert(plan.size(), r);
	endfunction

	initial begin
		logic [15:0] turn;
		logic [23:0] step;
		int          goal;
		int          r;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_TURN_ANGLE;
		cfg_data = '0;
		item_valid = 1'b0;
		symbol = SYM_G;
		first_of_string = 1'b0;
		drive_typed = 1'b0;
		drive_want = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		add_row(typed_row(SYM_POP, 1'b0, POP_EMPTY_SEG));
		add_row(symbol_row(SYM_G, 1'b0, 1));
		add_row(symbol_row(SYM_F, 1'b0, 1));
		add_row(reg_row(REG_TURN_ANGLE, 24'd16384));
		add_row(symbol_row(SYM_PLUS, 1'b0, 1));
		add_row(symbol_row(SYM_G, 1'b0, 1));
		add_row(symbol_row(SYM_MINUS, 1'b0, 2));
		add_row(symbol_row(SYM_F, 1'b0, 1));
		add_row(reg_row(REG_STEP_LENGTH, 24'd0));
		add_row(typed_row(SYM_G, 1'b1, ORIGIN_SEG));
		add_row(reg_row(REG_STEP_LENGTH, 24'hFF_FFFF));
		add_row(reg_row(REG_TURN_ANGLE, 24'h00_FFFF));
		add_row(symbol_row(SYM_PUSH, 1'b0, 1));
		add_row(symbol_row(SYM_PLUS, 1'b0, 1));
		add_row(symbol_row(SYM_G, 1'b0, 1));
		add_row(symbol_row(SYM_POP, 1'b0, 1));
		add_row(symbol_row(SYM_G, 1'b0, 1));
		add_row(symbol_row(SYM_NOP_LO, 1'b0, 1));
		add_row(symbol_row(SYM_NOP_MID, 1'b0, 1));
		add_row(symbol_row(SYM_NOP_HI, 1'b0, 1));
		add_row(symbol_row(SYM_F, 1'b1, 1));
		// Runs at the largest step, most from the origin, drive each coordinate into saturation.
		add_row(symbol_row(SYM_G, 1'b0, SAT_RUN));
		add_row(reg_row(REG_TURN_ANGLE, 24'd16384));
		add_row(symbol_row(SYM_PLUS, 1'b1, 1));
		add_row(symbol_row(SYM_G, 1'b0, SAT_RUN));
		add_row(symbol_row(SYM_MINUS, 1'b1, 1));
		add_row(symbol_row(SYM_F, 1'b0, SAT_RUN));
		add_row(symbol_row(SYM_MINUS, 1'b0, 1));
		add_row(symbol_row(SYM_G, 1'b0, SAT_RUN));
		add_row(symbol_row(SYM_PUSH, 1'b1, 1));
		add_row(symbol_row(SYM_PUSH, 1'b0, STACK_DEPTH - 1));
		add_row(typed_row(SYM_PUSH, 1'b0, PUSH_FULL_SEG));
		add_row(symbol_row(SYM_POP, 1'b0, STACK_DEPTH));
		add_row(typed_row(SYM_POP, 1'b0, POP_EMPTY_SEG));
		add_row(symbol_row(SYM_PUSH, 1'b0, 3));
		add_row(typed_row(SYM_POP, 1'b1, POP_EMPTY_SEG));
		add_row(reg_row(REG_TURN_ANGLE, 24'd0));
		add_row(symbol_row(SYM_PLUS, 1'b0, 1));
		add_row(symbol_row(SYM_G, 1'b0, 1));

		foreach (plan[n]) begin
			if (plan[n].kind == ROW_REG)
				write_reg(plan[n].cfg_idx, plan[n].value);
			else
				repeat (plan[n].reps)
					send_symbol(plan[n].sym, plan[n].first, plan[n].typed, plan[n].want);
		end

		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 0) begin
				turn = 16'hFFFF;
				step = 24'hFF_FFFF;
			end else if (ph == 1) begin
				turn = 16'd0;
				step = 24'd1;
			end else begin
				case ($urandom_range(3))
					0:       turn = 16'hFFFF;
					1:       turn = 16'd16384;
					2:       turn = 16'($urandom_range(255));
					default: turn = 16'($urandom);
				endcase
				case ($urandom_range(4))
					0:       step = 24'hFF_FFFF;
					1:       step = 24'd65536;
					2:       step = 24'($urandom_range(65535));
					3:       step = 24'($urandom);
					default: step = 24'($urandom_range(4095));
				endcase
			end
			write_reg(REG_TURN_ANGLE, {8'($urandom), turn});
			write_reg(REG_STEP_LENGTH, step);
			if (ph == 2)
				hold_req = 1;
			calm = (ph == 3);
			goal = items_sent + PHASE_ITEMS;
			while (items_sent < goal) begin
				r = $urandom_range(99);
				if (r < 75)
					send_string();
				else if (r < 80)
					send_pile();
				else
					send_noise();
			end
		end
		calm = 0;

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (faults == 0 && segments.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> bracketed_turtle_interpreter.f
+incdir+hw/rtl
hw/rtl/bti_pkg.sv
hw/rtl/bracketed_turtle_interpreter.sv
tb/tb.sv
